// File: src/bad_pkg.sv
// shared types and constants of the block-average downsampler
// no dependencies; used by the channel interfaces and the top level
package bad_pkg;

  localparam int PIX_W = 8;   // grey level
  localparam int DIM_W = 9;   // frame width / height registers
  localparam int POS_W = 8;   // region offsets and column position
  localparam int IDX_W = 12;  // feature index
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = DIM_W;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_REGION_LEFT  = 2'd2,
    CFG_REGION_TOP   = 2'd3
  } cfg_reg_t;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 9'd32;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 9'd32;
  localparam logic [DIM_W-1:0] MAX_IMAGE_HEIGHT = 9'd256;

  // position flags of a pixel within its block, carried to the sum stage
  typedef struct packed {
    logic fs;    // pixel opened a frame
    logic blk;   // pixel lies in a complete block of the region
    logic cx0;   // first column of its block
    logic cxl;   // last column of its block
    logic cy0;   // first line of its block
    logic cyl;   // last line of its block
    logic last;  // block is the bottom-right complete block
  } bad_pos_t;

endpackage

// File: src/bad_pix_if.sv
// pixel channel: valid/ready handshake with grey level and frame marker
// depends on bad_pkg
interface bad_pix_if import bad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// File: src/bad_feat_if.sv
// feature channel: valid/ready handshake with block mean, index and last flag
// depends on bad_pkg
interface bad_feat_if import bad_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] feature_value;
  logic [IDX_W-1:0] feature_index;
  logic             last_feature;

  modport source (output valid, feature_value, feature_index, last_feature, input ready);
  modport sink   (input valid, feature_value, feature_index, last_feature, output ready);
endinterface

// File: src/block_average_downsampler.sv
// block-average downsampler: sum stage and result register lie between pixel and feature
// one pixel per cycle unless the output stalls; block sums are read at pixel transfer
// and written as the pixel leaves the sum stage, so one read and one write port suffice
// reset (rst_n low, synchronous) clears position, counters and both stage valids,
// and loads the registers with width 32, height 32, left 0, top 0
// the block-sum memory is not cleared; the first line of each block row ignores it
module block_average_downsampler import bad_pkg::*; #(
  parameter int BLOCK_SIDE      = 4,
  parameter int MAX_LINE_PIXELS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bad_pix_if.sink               in_pix,
  bad_feat_if.source            out_feat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // line length is limited by both the parameter and the 8-bit column position
  localparam int LIM_W = (MAX_LINE_PIXELS < 256) ? MAX_LINE_PIXELS : 256;
  localparam int NCOL  = LIM_W / BLOCK_SIDE;
  localparam int AW    = (NCOL > 1) ? $clog2(NCOL) : 1;
  localparam int PW    = $clog2(BLOCK_SIDE * 255 + 1);
  localparam int AREA  = BLOCK_SIDE * BLOCK_SIDE;
  localparam int SW    = $clog2(AREA * 255 + 1);

  // divide by block side: multiply by a rounded-up reciprocal with 16 fraction bits;
  // the fraction tells the column within the block
  localparam logic [16:0] RCP_M   = 17'(((1 << 16) + BLOCK_SIDE - 1) / BLOCK_SIDE);
  localparam logic [16:0] FR_ONE  = 17'((1 << 16) / BLOCK_SIDE);
  localparam logic [16:0] FR_LAST = 17'(((BLOCK_SIDE - 1) << 16) / BLOCK_SIDE);

  // divide by block area: exact reciprocal for every sum below 2^SW
  localparam int DIV_L  = $clog2(AREA);
  localparam int DIV_SH = SW + DIV_L;
  localparam int MW     = DIV_SH + 1;
  localparam logic [MW-1:0] DIV_M = MW'(((64'd1 << DIV_SH) + AREA - 1) / AREA);

  localparam logic [DIM_W-1:0] LIM_W_V = DIM_W'(LIM_W);

  // configuration registers
  logic [DIM_W-1:0] img_w_r, img_h_r;
  logic [POS_W-1:0] left_r, top_r;

  // raster position of the next pixel
  logic [POS_W-1:0] col_x_r;
  logic [DIM_W-1:0] line_y_r;

  // sum stage
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  bad_pos_t         s1_pos_r;
  logic [AW-1:0]    s1_bx_r;
  logic [SW-1:0]    rd_r;
  logic [PW-1:0]    row_part_r;
  logic [IDX_W-1:0] count_r;
  logic [SW-1:0]    bsum_mem [NCOL];

  // result register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_value_r;
  logic [IDX_W-1:0] out_index_r;
  logic             out_last_r;

  // ---------------------------------------------------------------------------
  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      left_r  <= '0;
      top_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_data;
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_data;
        CFG_REGION_LEFT:  left_r  <= cfg_data[POS_W-1:0];
        CFG_REGION_TOP:   top_r   <= cfg_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // position decode at pixel transfer
  logic             in_xfer, in_rdy, s1_go, s1_emit, out_free;
  logic [DIM_W-1:0] w_eff, h_eff, span_w, span_h, bw, bh, x_inc;
  logic [POS_W-1:0] x_cur, rx, ry, bx, by;
  logic [DIM_W-1:0] y_cur;
  logic [25:0]      prod_bw, prod_bh;
  logic [24:0]      prod_x, prod_y;
  logic             in_reg;
  bad_pos_t         pos;
  logic [POS_W-1:0] col_x_nxt;
  logic [DIM_W-1:0] line_y_nxt;

  always_comb begin
    // zero dimensions count as one, oversized ones are clamped
    if (img_w_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (img_w_r > LIM_W_V) begin
      w_eff = LIM_W_V;
    end else begin
      w_eff = img_w_r;
    end
    if (img_h_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (img_h_r > MAX_IMAGE_HEIGHT) begin
      h_eff = MAX_IMAGE_HEIGHT;
    end else begin
      h_eff = img_h_r;
    end

    // frame marker puts this pixel at the origin
    x_cur = in_pix.frame_start ? '0 : col_x_r;
    y_cur = in_pix.frame_start ? '0 : line_y_r;

    // complete blocks across and down the region
    span_w  = (w_eff > {1'b0, left_r}) ? w_eff - {1'b0, left_r} : '0;
    span_h  = (h_eff > {1'b0, top_r})  ? h_eff - {1'b0, top_r}  : '0;
    prod_bw = span_w * RCP_M;
    prod_bh = span_h * RCP_M;
    bw      = prod_bw[24:16];
    bh      = prod_bh[24:16];

    rx     = x_cur - left_r;
    ry     = y_cur[POS_W-1:0] - top_r;
    prod_x = rx * RCP_M;
    prod_y = ry * RCP_M;
    bx     = prod_x[23:16];
    by     = prod_y[23:16];

    in_reg   = (y_cur < h_eff) && (x_cur >= left_r) && (y_cur >= {1'b0, top_r});
    pos.fs   = in_pix.frame_start;
    pos.blk  = in_reg && ({1'b0, bx} < bw) && ({1'b0, by} < bh);
    pos.cx0  = {1'b0, prod_x[15:0]} < FR_ONE;
    pos.cxl  = {1'b0, prod_x[15:0]} >= FR_LAST;
    pos.cy0  = {1'b0, prod_y[15:0]} < FR_ONE;
    pos.cyl  = {1'b0, prod_y[15:0]} >= FR_LAST;
    pos.last = ({1'b0, bx} == bw - DIM_W'(1)) && ({1'b0, by} == bh - DIM_W'(1));

    // raster advance; past the last line the position holds
    x_inc      = {1'b0, x_cur} + DIM_W'(1);
    col_x_nxt  = x_cur;
    line_y_nxt = y_cur;
    if (y_cur < h_eff) begin
      if (x_inc >= w_eff) begin
        col_x_nxt  = '0;
        line_y_nxt = y_cur + DIM_W'(1);
      end else begin
        col_x_nxt = x_inc[POS_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // handshake: the sum stage drains when its result, if any, has a free slot
  assign out_free        = !out_valid_r || out_feat.ready;
  assign s1_emit         = s1_pos_r.blk && s1_pos_r.cxl && s1_pos_r.cyl;
  assign s1_go           = s1_valid_r && (!s1_emit || out_free);
  assign in_rdy          = !s1_valid_r || s1_go;
  assign in_pix.ready    = in_rdy;
  assign in_xfer         = in_pix.valid && in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_x_r    <= '0;
      line_y_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_x_r  <= col_x_nxt;
        line_y_r <= line_y_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r <= in_pix.pixel;
      s1_pos_r <= pos;
      s1_bx_r  <= bx[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // sum stage: line partial, column sum from memory, block mean
  logic [PW-1:0]        part_eff, cur;
  logic [SW-1:0]        acc;
  logic [IDX_W-1:0]     count_eff, count_nxt;
  logic [PW-1:0]        row_part_nxt;
  logic [SW+MW-1:0]     mean_prod;
  logic                 mem_we;

  always_comb begin
    part_eff  = s1_pos_r.fs ? '0 : row_part_r;
    cur       = (s1_pos_r.cx0 ? '0 : part_eff) + PW'(s1_pix_r);
    acc       = (s1_pos_r.cy0 ? '0 : rd_r) + SW'(cur);
    mean_prod = acc * DIV_M;
    count_eff = s1_pos_r.fs ? '0 : count_r;
    count_nxt = s1_emit ? count_eff + IDX_W'(1) : count_eff;
    if (s1_pos_r.blk) begin
      row_part_nxt = s1_pos_r.cxl ? '0 : cur;
    end else begin
      row_part_nxt = part_eff;
    end
    mem_we = s1_go && s1_pos_r.blk && s1_pos_r.cxl && !s1_pos_r.cyl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_part_r <= '0;
      count_r    <= '0;
    end else if (s1_go) begin
      row_part_r <= row_part_nxt;
      count_r    <= count_nxt;
    end
  end

  // column sums of the current block row; a column is never read within
  // one line of its write, so the read port needs no bypass
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bsum_mem[s1_bx_r] <= acc;
    end
    if (in_xfer) begin
      rd_r <= bsum_mem[bx[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_feat.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_value_r <= mean_prod[DIV_SH +: PIX_W];
      out_index_r <= count_eff;
      out_last_r  <= s1_pos_r.last;
    end
  end

  assign out_feat.valid         = out_valid_r;
  assign out_feat.feature_value = out_value_r;
  assign out_feat.feature_index = out_index_r;
  assign out_feat.last_feature  = out_last_r;

  // ---------------------------------------------------------------------------
  // checks

  // input stalls only when both stages are full and the result is not taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rdy |-> (s1_valid_r && out_valid_r && !out_feat.ready))
    else $error("input stalled with room in the pipeline");

  // every emitted feature within a frame advances the index by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_emit && !s1_pos_r.fs) |=> (count_r == $past(count_r) + IDX_W'(1)))
    else $error("feature index did not advance");

  // a feature is loaded only from a pixel on the last line of a complete block
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r)) |-> $past(s1_valid_r && s1_pos_r.blk && s1_pos_r.cyl))
    else $error("feature from a pixel that closes no block");

  // reset leaves both stages empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !s1_valid_r))
    else $error("stage valid after reset");

endmodule

// File: tb/sv/tb_block_average_downsampler.sv
`timescale 1ns / 1ps
// self-checking bench of block_average_downsampler: directed and random frames, features
// compared with an in-bench block-mean model; needs bad_pkg, bad_pix_if, bad_feat_if and the dut
module tb_block_average_downsampler;
  import bad_pkg::*;

  localparam int SIDE = 4;                     // block edge, matches the dut parameter
  localparam int LINE_MAX = 256;               // widest line the dut holds sums for
  localparam int SUM_COLS = LINE_MAX / SIDE;
  localparam int RANDOM_PIXELS = 750;          // placed pixels in the random part
  localparam int MIN_RANDOM_MEANS = 48;        // features the random part should cause
  localparam int SETTLE_CYCLES = 8;            // margin after the features drain, for pixel-only work
  localparam int IDLE_LIMIT = 5000;            // cycles with no transfer at all before giving up
  localparam int MAX_REPORTS = 40;

  // one feature as the dut should deliver it
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [IDX_W-1:0] index;
    logic             last;
  } block_mean_t;

  typedef enum int {FILL_RANDOM, FILL_EXTREMES, FILL_FLAT} fill_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  sink_ready = 1'b0;

  bad_pix_if  pix_if();
  bad_feat_if feat_if();

  assign feat_if.ready = sink_ready;

  block_average_downsampler #(
    .BLOCK_SIDE(SIDE),
    .MAX_LINE_PIXELS(LINE_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_pix(pix_if),
    .out_feat(feat_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // block-mean model: register copy, raster position and partial sums
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] cur_width;
  logic [DIM_W-1:0] cur_height;
  logic [POS_W-1:0] cur_left;
  logic [POS_W-1:0] cur_top;
  logic [8:0]       next_col;             // column of the next pixel
  logic [8:0]       next_line;            // line of the next pixel, reaches 256 past the end
  logic [11:0]      line_run_sum;         // current block, current line so far
  logic [11:0]      strip_sums [SUM_COLS]; // per block column, lines above in this block row
  logic [IDX_W-1:0] means_in_frame;

  block_mean_t pending_means[$];          // features still owed by the dut

  int  errors;
  int  pixels_sent;
  int  placed_pixels;                     // pixels that advanced the raster position
  int  means_predicted;
  int  means_checked;
  int  settings_applied;
  int  stuck_cycles;
  int  stall_left;
  bit  calm;                              // no gaps and no stalls while set

  function automatic int clamp_size(logic [DIM_W-1:0] v, int lim);
    if (v == '0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  // advance the model by one transferred pixel, queue a feature when a block closes
  function automatic void accumulate_pixel(logic [PIX_W-1:0] pix, logic fs);
    int w, h, left, top, x, y, blocks_x, blocks_y, bx, by, cx, cy, run, total;
    block_mean_t m;
    w = clamp_size(cur_width, LINE_MAX);
    h = clamp_size(cur_height, 256);
    left = int'(cur_left);
    top = int'(cur_top);
    if (fs) begin
      next_col = '0;
      next_line = '0;
      line_run_sum = '0;
      means_in_frame = '0;
    end
    x = int'(next_col);
    y = int'(next_line);
    // only whole blocks count, the ragged right and bottom edge is dropped
    blocks_x = (w > left) ? (w - left) / SIDE : 0;
    blocks_y = (h > top) ? (h - top) / SIDE : 0;
    if (y < h && x >= left && y >= top) begin
      bx = (x - left) / SIDE;
      cx = (x - left) % SIDE;
      by = (y - top) / SIDE;
      cy = (y - top) % SIDE;
      if (bx < blocks_x && by < blocks_y) begin
        run = (cx == 0 ? 0 : int'(line_run_sum)) + int'(pix);
        if (cx == SIDE - 1) begin
          total = (cy == 0 ? 0 : int'(strip_sums[bx])) + run;
          line_run_sum = '0;
          if (cy == SIDE - 1) begin
            m.value = PIX_W'(total / (SIDE * SIDE));
            m.index = means_in_frame;
            m.last = (bx == blocks_x - 1) && (by == blocks_y - 1);
            pending_means.push_back(m);
            means_in_frame = means_in_frame + 1'b1;
            means_predicted++;
          end else begin
            strip_sums[bx] = 12'(total);
          end
        end else begin
          line_run_sum = 12'(run);
        end
      end
    end
    // past the last line the position holds until the next frame start
    if (y < h) begin
      placed_pixels++;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
      end
      next_col = 9'(x);
      next_line = 9'(y);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // feature side: random stalls, checking, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : stall_gen
    int r;
    if (calm) begin
      sink_ready <= 1'b1;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        sink_ready <= 1'b1;
      end else begin
        sink_ready <= 1'b0;
        // mostly short stalls, now and then a long one
        stall_left <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(3, 30);
      end
    end
  end

  function automatic void flag_mismatch(string field, logic [IDX_W-1:0] want,
                                        logic [IDX_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  // compare every feature transfer with the oldest pending one
  always @(posedge clk) begin : mean_check
    block_mean_t got, want;
    if (rst_n && feat_if.valid && feat_if.ready) begin
      got.value = feat_if.feature_value;
      got.index = feat_if.feature_index;
      got.last = feat_if.last_feature;
      means_checked++;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: feature with nothing pending, expected none, got value %0d index %0d last %0d",
                   $time, got.value, got.index, got.last);
      end else begin
        want = pending_means.pop_front();
        if (got.value !== want.value) flag_mismatch("feature_value", want.value, got.value);
        if (got.index !== want.index) flag_mismatch("feature_index", want.index, got.index);
        if (got.last !== want.last) flag_mismatch("last_feature", want.last, got.last);
      end
    end
  end

  // a hang shows as a long stretch with no transfer on either channel
  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (feat_if.valid && feat_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d features pending",
               $time, stuck_cycles, pending_means.size());
      $display("tb_block_average_downsampler failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // pixel side
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // one pixel transfer; valid stays high into the next call when there is no gap
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= pix;
    pix_if.frame_start <= fs;
    do @(posedge clk); while (!pix_if.ready);
    accumulate_pixel(pix, fs);
    pixels_sent++;
  endtask

  // stop sending and wait for every owed feature; the wait checks after each clock edge
  task automatic await_means();
    pix_if.valid <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
  endtask

  // idle point for register writes: features drained, pixel-only work finished too
  task automatic settle();
    await_means();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all four registers, one write per cycle; bit 8 of the offsets is don't-care
  task automatic load_registers(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [POS_W-1:0] left, input logic [POS_W-1:0] top);
    cfg_reg_t              order [4];
    logic [CFG_DATA_W-1:0] vals [4];
    order = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_REGION_LEFT, CFG_REGION_TOP};
    vals = '{w, h, {$urandom_range(0, 1) == 1, left}, {$urandom_range(0, 1) == 1, top}};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_width = w;
    cur_height = h;
    cur_left = left;
    cur_top = top;
    settings_applied++;
  endtask

  // stream count pixels; optional frame start on the first, optional stray restarts,
  // and an optional pause until drained before pixel pause_at
  task automatic send_frame(input int count, input fill_t fill, input logic [PIX_W-1:0] level,
                            input int pause_at, input bit open_frame, input bit restarts);
    logic [PIX_W-1:0] pix;
    logic             fs;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) await_means();
      case (fill)
        FILL_RANDOM:   pix = PIX_W'($urandom_range(0, 255));
        FILL_EXTREMES: pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:       pix = level;
      endcase
      fs = (i == 0) ? open_frame : (restarts && $urandom_range(0, 149) == 0);
      send_pixel(pix, fs);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset registers (32x32 from the origin), no frame start: four lines give 8 features
  task automatic test_after_reset();
    send_frame(4 * 32, FILL_RANDOM, '0, -1, 1'b0, 1'b0);
  endtask

  // one 4x4 frame of full-scale pixels, then two pixels past the last line
  task automatic test_full_scale_block();
    settle();
    load_registers(9'd4, 9'd4, 8'd0, 8'd0);
    send_frame(16, FILL_FLAT, 8'hFF, -1, 1'b1, 1'b0);
    send_pixel(8'h00, 1'b0);
    send_pixel(8'h5A, 1'b0);
  endtask

  // zero sizes act as 1x1; largest offsets leave a region too small for a block
  task automatic test_degenerate_sizes();
    settle();
    load_registers(9'd0, 9'd0, 8'd0, 8'd0);
    send_pixel(8'h81, 1'b1);
    send_pixel(8'h7E, 1'b0);
    send_pixel(8'hFF, 1'b0);
    settle();
    load_registers(9'd256, 9'd256, 8'd255, 8'd255);
    send_frame(4, FILL_RANDOM, '0, -1, 1'b1, 1'b0);
  endtask

  // height raised between block rows while the frame is open: new rows and a later last flag
  task automatic test_midframe_config();
    settle();
    load_registers(9'd8, 9'd8, 8'd0, 8'd0);
    send_frame(4 * 8, FILL_RANDOM, '0, -1, 1'b1, 1'b0);
    settle();
    load_registers(9'd8, 9'd12, 8'd0, 8'd0);
    send_frame(8 * 8, FILL_RANDOM, '0, -1, 1'b0, 1'b0);
  endtask

  // width beyond the line limit clamps to 256; only the rightmost block fits the region
  task automatic test_wide_line();
    settle();
    load_registers(9'd511, 9'd4, 8'd252, 8'd0);
    send_frame(256 * 4 + 2, FILL_RANDOM, '0, -1, 1'b1, 1'b0);
  endtask

  // height beyond 256 clamps; the two bottom block rows of a one-block-wide frame
  task automatic test_tall_frame();
    settle();
    load_registers(9'd4, 9'd511, 8'd0, 8'd248);
    send_frame(4 * 256 + 2, FILL_RANDOM, '0, -1, 1'b1, 1'b0);
  endtask

  // random small frames: mostly whole frames, some cut short or with a ragged tail,
  // a few with degenerate or empty regions, and pauses until drained now and then
  task automatic test_random_frames();
    int               w, h, left, top, kind, span, count, pause_at, r, start_pixels, start_means;
    fill_t            fill;
    logic [PIX_W-1:0] level;
    bit               paused_once;
    start_pixels = placed_pixels;
    start_means = means_predicted;
    paused_once = 1'b0;
    while (placed_pixels - start_pixels < RANDOM_PIXELS ||
           means_predicted - start_means < MIN_RANDOM_MEANS) begin
      kind = $urandom_range(0, 9);
      w = $urandom_range(4, 20);
      h = $urandom_range(4, 12);
      left = $urandom_range(0, 5);
      top = $urandom_range(0, 4);
      if (kind == 7) begin
        w = $urandom_range(0, 3);
        h = $urandom_range(0, 5);
      end else if (kind == 8) begin
        left = $urandom_range(w, 255);          // region starts right of the line
      end else if (kind == 9) begin
        top = $urandom_range(h, 255);           // region starts below the frame
      end
      settle();
      load_registers(DIM_W'(w), DIM_W'(h), POS_W'(left), POS_W'(top));
      span = (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
      repeat ($urandom_range(1, 3)) begin
        calm = ($urandom_range(0, 4) == 0);
        fill = fill_t'($urandom_range(0, 2));
        r = $urandom_range(0, 3);
        level = (r == 0) ? 8'hFF : (r == 1) ? 8'h00 : PIX_W'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        count = span;
        if (r < 3) count = $urandom_range(1, span);
        else if (r < 6) count = span + $urandom_range(1, 6);
        pause_at = (!paused_once || $urandom_range(0, 5) == 0) ? $urandom_range(0, count - 1) : -1;
        paused_once = 1'b1;
        send_frame(count, fill, level, pause_at, 1'b1, 1'b1);
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    // every dut input known from time zero, reset held low at the start
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.frame_start = 1'b0;
    calm = 1'b0;
    stall_left = 0;
    stuck_cycles = 0;
    errors = 0;
    pixels_sent = 0;
    placed_pixels = 0;
    means_predicted = 0;
    means_checked = 0;
    settings_applied = 0;
    cur_width = RST_IMAGE_WIDTH;
    cur_height = RST_IMAGE_HEIGHT;
    cur_left = '0;
    cur_top = '0;
    next_col = '0;
    next_line = '0;
    line_run_sum = '0;
    means_in_frame = '0;
    for (int i = 0; i < SUM_COLS; i++) strip_sums[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_full_scale_block();
    test_degenerate_sizes();
    test_midframe_config();
    test_wide_line();
    test_tall_frame();
    test_random_frames();

    settle();
    $display("covered %0d pixel transfers and %0d checked features under %0d register settings",
             pixels_sent, means_checked, settings_applied);
    $display("settings included reset values, clamped and zero sizes, empty and mid-frame regions");
    if (errors == 0 && pending_means.size() == 0) begin
      $display("tb_block_average_downsampler passed");
    end else begin
      $display("tb_block_average_downsampler failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/bad_pkg.sv
src/bad_pix_if.sv
src/bad_feat_if.sv
src/block_average_downsampler.sv
tb/sv/tb_block_average_downsampler.sv
